>>> design/dsmb_pkg.sv
// Shared types and constants for the depth-scaled motion blur core.
// No dependencies.
package dsmb_pkg;
    localparam int DefMaxSpan     = 32;
    localparam int DefMaxRowWidth = 4096;
    localparam int ChanW          = 16;
    localparam int DepthW         = 24;
    localparam int ShiftW         = 12;
    localparam int AccW           = 22;
    localparam int OutW           = 13;
    localparam int DqW            = 20;   // quotient of span division, Q.8
    localparam int ShareW         = 24;   // channel*256/dq
    localparam logic [AccW-1:0] AccMax = '1;
    localparam logic [OutW-1:0] OneQ12 = 13'd4096;
    localparam logic [DepthW-1:0] NonFiniteDepth = 24'd256000;
    localparam logic [3:0] RegBlurShift = 4'd0;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic [ShareW-1:0] sr;
        logic [ShareW-1:0] sg;
        logic [ShareW-1:0] sb;
        logic [DqW-1:0]    dq;
        logic              row_end;
    } t_job;

    typedef enum logic [2:0] {
        FR_IDLE, FR_SPAN, FR_SHARE, FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE, BK_ADD, BK_EMIT, BK_FLUSH, BK_CLEAR
    } t_back_state;
endpackage

>>> design/dsmb_front.sv
// Front part: computes span dq and the per-channel shares with serial dividers.
// Depends on dsmb_pkg.
module dsmb_front #(
    parameter int MaxSpan = dsmb_pkg::DefMaxSpan
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dsmb_pkg::ShiftW-1:0]   i_blur_shift,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [dsmb_pkg::ChanW-1:0]    i_red,
    input  logic [dsmb_pkg::ChanW-1:0]    i_green,
    input  logic [dsmb_pkg::ChanW-1:0]    i_blue,
    input  logic [dsmb_pkg::DepthW-1:0]   i_depth,
    input  logic                          i_depth_finite,
    input  logic                          i_row_end,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output dsmb_pkg::t_job                o_job
);
    import dsmb_pkg::*;
    localparam int NumW = 32;   // blur_shift*655360 < 2^32
    localparam int DenW = 29;
    localparam int CntW = 5;

    t_front_state r_st, n_st;
    logic [NumW-1:0] r_num, n_num;     // dividend shifting left
    logic [DenW+1:0] r_rem, n_rem;
    logic [DenW-1:0] r_den, n_den;
    logic [NumW-1:0] r_quo, n_quo;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [ChanW-1:0] r_r, r_g, r_b;
    logic r_re;
    // share dividers: three in parallel, 24-bit dividends
    logic [ShareW-1:0] r_nr, r_ng, r_nb, n_nr, n_ng, n_nb;
    logic [DqW:0] r_rr, r_rg, r_rb, n_rr, n_rg, n_rb;
    logic [ShareW-1:0] r_qr, r_qg, r_qb, n_qr, n_qg, n_qb;
    logic [DqW-1:0] r_dq, n_dq;
    logic [DenW+1:0] t_rem;
    logic [DqW:0] t_rr, t_rg, t_rb;
    logic [DepthW-1:0] dep;
    logic [NumW-1:0] q_raw;

    assign dep = i_depth_finite ? i_depth : NonFiniteDepth;
    assign q_raw = r_quo;

    always_comb begin
        n_st = r_st;
        case (r_st)
            FR_IDLE:  if (i_push) n_st = FR_SPAN;
            FR_SPAN:  if (r_cnt == CntW'(NumW-1)) n_st = FR_SHARE;
            FR_SHARE: if (r_cnt == CntW'(ShareW-1)) n_st = FR_PUSH;
            FR_PUSH:  if (i_job_ready) n_st = FR_IDLE;
            default:  n_st = FR_IDLE;
        endcase
    end

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_den = r_den; n_quo = r_quo; n_cnt = r_cnt;
        n_nr = r_nr; n_ng = r_ng; n_nb = r_nb;
        n_rr = r_rr; n_rg = r_rg; n_rb = r_rb;
        n_qr = r_qr; n_qg = r_qg; n_qb = r_qb; n_dq = r_dq;
        t_rem = '0; t_rr = '0; t_rg = '0; t_rb = '0;
        case (r_st)
            FR_IDLE: begin
                n_num = NumW'(i_blur_shift) * NumW'(655360);
                n_den = DenW'(dep) * DenW'(10) + DenW'(256);
                n_rem = '0; n_quo = '0; n_cnt = '0;
            end
            FR_SPAN: begin
                t_rem = {r_rem[DenW:0], r_num[NumW-1]};
                n_num = r_num << 1;
                if (t_rem >= (DenW+2)'(r_den)) begin
                    n_rem = t_rem - (DenW+2)'(r_den);
                    n_quo = {r_quo[NumW-2:0], 1'b1};
                end else begin
                    n_rem = t_rem;
                    n_quo = {r_quo[NumW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntW'(NumW-1)) begin
                    n_cnt = '0;
                    n_nr = {r_r, 8'd0}; n_ng = {r_g, 8'd0}; n_nb = {r_b, 8'd0};
                    n_rr = '0; n_rg = '0; n_rb = '0;
                end
            end
            FR_SHARE: begin
                if (r_cnt == '0) begin
                    // clamp span to [1, MAX_SPAN] once the quotient is final
                    if (q_raw < NumW'(256)) n_dq = DqW'(256);
                    else if (q_raw > NumW'(MaxSpan*256)) n_dq = DqW'(MaxSpan*256);
                    else n_dq = DqW'(q_raw);
                end
                t_rr = {r_rr[DqW-1:0], r_nr[ShareW-1]};
                t_rg = {r_rg[DqW-1:0], r_ng[ShareW-1]};
                t_rb = {r_rb[DqW-1:0], r_nb[ShareW-1]};
                n_nr = r_nr << 1; n_ng = r_ng << 1; n_nb = r_nb << 1;
                if (t_rr >= (DqW+1)'(n_dq)) begin
                    n_rr = t_rr - (DqW+1)'(n_dq); n_qr = {r_qr[ShareW-2:0], 1'b1};
                end else begin
                    n_rr = t_rr; n_qr = {r_qr[ShareW-2:0], 1'b0};
                end
                if (t_rg >= (DqW+1)'(n_dq)) begin
                    n_rg = t_rg - (DqW+1)'(n_dq); n_qg = {r_qg[ShareW-2:0], 1'b1};
                end else begin
                    n_rg = t_rg; n_qg = {r_qg[ShareW-2:0], 1'b0};
                end
                if (t_rb >= (DqW+1)'(n_dq)) begin
                    n_rb = t_rb - (DqW+1)'(n_dq); n_qb = {r_qb[ShareW-2:0], 1'b1};
                end else begin
                    n_rb = t_rb; n_qb = {r_qb[ShareW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FR_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem; r_den <= n_den; r_quo <= n_quo;
        r_nr <= n_nr; r_ng <= n_ng; r_nb <= n_nb;
        r_rr <= n_rr; r_rg <= n_rg; r_rb <= n_rb;
        r_qr <= n_qr; r_qg <= n_qg; r_qb <= n_qb; r_dq <= n_dq;
        if (r_st == FR_IDLE && i_push) begin
            r_r <= i_red; r_g <= i_green; r_b <= i_blue; r_re <= i_row_end;
        end
    end

    assign o_full = (r_st != FR_IDLE);
    assign o_job_valid = (r_st == FR_PUSH);
    assign o_job = '{sr: r_qr, sg: r_qg, sb: r_qb, dq: r_dq, row_end: r_re};

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (o_job.dq >= DqW'(256) && o_job.dq <= DqW'(MaxSpan*256)))
        else $error("span out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !o_full |=> o_full)
        else $error("front not busy after accept");
endmodule

>>> design/dsmb_queue.sv
// Short job queue between front and back parts.
// Depends on dsmb_pkg.
module dsmb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    output logic           o_wr_ready,
    input  dsmb_pkg::t_job i_data,
    output logic           o_rd_valid,
    input  logic           i_rd,
    output dsmb_pkg::t_job o_data
);
    import dsmb_pkg::*;
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_wr && o_wr_ready) r_wp <= ~r_wp;
            if (i_rd && o_rd_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_wr && o_wr_ready) ? 1 : 0)
                           - 2'((i_rd && o_rd_valid) ? 1 : 0);
        end
        if (i_wr && o_wr_ready) r_mem[r_wp] <= i_data;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers inconsistent");
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_rd |=> r_cnt == 2'd2)
        else $error("queue lost entry");
endmodule

>>> design/dsmb_back.sv
// Back part: adds each pixel's span into a shifting accumulator window, emits
// finished positions and flushes rows. Depends on dsmb_pkg.
module dsmb_back #(
    parameter int MaxSpan     = dsmb_pkg::DefMaxSpan,
    parameter int MaxRowWidth = dsmb_pkg::DefMaxRowWidth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_take,
    input  dsmb_pkg::t_job              i_job,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [dsmb_pkg::OutW-1:0]   o_out_red,
    output logic [dsmb_pkg::OutW-1:0]   o_out_green,
    output logic [dsmb_pkg::OutW-1:0]   o_out_blue,
    output logic                        o_out_row_end
);
    import dsmb_pkg::*;
    // entry k of the window holds position col - Back + k
    localparam int Win  = MaxSpan;
    localparam int Back = MaxSpan / 2;
    localparam int ColW = $clog2(MaxRowWidth);
    localparam int FkW  = $clog2(Back + 1);

    t_back_state r_st, n_st;
    logic [AccW-1:0] r_wr [Win];
    logic [AccW-1:0] r_wg [Win];
    logic [AccW-1:0] r_wb [Win];
    logic [ColW-1:0] r_col;
    logic [FkW-1:0]  r_fk;       // window slides done during a row flush
    logic r_ov;
    logic [OutW-1:0] r_or, r_og, r_ob;
    logic r_ore;
    t_job r_job;
    logic [Win-1:0] hit;
    logic [DqW-1:0] reach_lo, reach_hi;
    logic row_last, need_emit, out_ok, do_emit, advance, emit_last;

    function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                                 input logic [ShareW-1:0] b);
        logic [ShareW:0] s;
        s = (ShareW+1)'(a) + (ShareW+1)'(b);
        return (s > (ShareW+1)'(AccMax)) ? AccMax : AccW'(s);
    endfunction

    function automatic logic [OutW-1:0] clamp_one(input logic [AccW-1:0] v);
        return (v > AccW'(OneQ12)) ? OneQ12 : OutW'(v);
    endfunction

    // pixel covers offsets -(dq>>9) .. (dq-1)>>9 around its column
    assign reach_lo = r_job.dq >> 9;
    assign reach_hi = (r_job.dq - DqW'(1)) >> 9;

    always_comb begin
        for (int k = 0; k < Win; k++) begin
            hit[k] = (DqW'(k) + reach_lo >= DqW'(Back))
                  && (DqW'(k) <= DqW'(Back) + reach_hi)
                  && ((ColW+1)'(r_col) + (ColW+1)'(k) >= (ColW+1)'(Back));
        end
    end

    assign row_last = r_job.row_end || (r_col == ColW'(MaxRowWidth - 1));

    // positions left of the row start slide out without leaving as a word
    always_comb begin
        case (r_st)
            BK_EMIT:  need_emit = (r_col >= ColW'(Back));
            BK_FLUSH: need_emit = ((ColW+1)'(r_col) + (ColW+1)'(r_fk) >= (ColW+1)'(Back));
            default:  need_emit = 1'b0;
        endcase
    end

    assign out_ok = o_empty || i_pop;
    assign do_emit = need_emit && out_ok;
    assign advance = (r_st == BK_EMIT || r_st == BK_FLUSH) && (!need_emit || out_ok);
    assign emit_last = (r_st == BK_FLUSH) && (r_fk == FkW'(Back));

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE:  if (i_job_valid) n_st = BK_ADD;
            BK_ADD:   n_st = row_last ? BK_FLUSH : BK_EMIT;
            BK_EMIT:  if (advance) n_st = BK_IDLE;
            BK_FLUSH: if (advance && emit_last) n_st = BK_CLEAR;
            BK_CLEAR: n_st = BK_IDLE;
            default:  n_st = BK_IDLE;
        endcase
    end

    assign o_job_take = (r_st == BK_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_col <= '0;
            r_fk <= '0;
            r_ov <= 1'b0;
            for (int k = 0; k < Win; k++) begin
                r_wr[k] <= '0; r_wg[k] <= '0; r_wb[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_ov <= do_emit || (r_ov && !i_pop);
            case (r_st)
                BK_ADD: begin
                    for (int k = 0; k < Win; k++) begin
                        if (hit[k]) begin
                            r_wr[k] <= sat_add(r_wr[k], r_job.sr);
                            r_wg[k] <= sat_add(r_wg[k], r_job.sg);
                            r_wb[k] <= sat_add(r_wb[k], r_job.sb);
                        end
                    end
                end
                BK_EMIT, BK_FLUSH: begin
                    if (advance) begin
                        // slide down one position; entry 0 has left
                        for (int k = 0; k < Win - 1; k++) begin
                            r_wr[k] <= r_wr[k+1]; r_wg[k] <= r_wg[k+1]; r_wb[k] <= r_wb[k+1];
                        end
                        r_wr[Win-1] <= '0; r_wg[Win-1] <= '0; r_wb[Win-1] <= '0;
                        if (r_st == BK_EMIT) r_col <= r_col + 1'b1;
                        else r_fk <= r_fk + 1'b1;
                    end
                end
                BK_CLEAR: begin
                    for (int k = 0; k < Win; k++) begin
                        r_wr[k] <= '0; r_wg[k] <= '0; r_wb[k] <= '0;
                    end
                    r_col <= '0;
                    r_fk <= '0;
                end
                default: ;
            endcase
        end
        if (o_job_take) r_job <= i_job;
        if (do_emit) begin
            r_or <= clamp_one(r_wr[0]);
            r_og <= clamp_one(r_wg[0]);
            r_ob <= clamp_one(r_wb[0]);
            r_ore <= emit_last;
        end
    end

    assign o_empty = !r_ov;
    assign o_out_red = r_or;
    assign o_out_green = r_og;
    assign o_out_blue = r_ob;
    assign o_out_row_end = r_ore;

    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == BK_CLEAR |=> r_col == '0) else $error("column not reset after row");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == BK_EMIT && do_emit |=> r_st == BK_IDLE) else $error("double emit");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit && r_st == BK_EMIT |=> !o_out_row_end) else $error("bad row end flag");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out_red) && $stable(o_out_row_end))
        else $error("waiting word changed");
endmodule

>>> design/depth_scaled_motion_blur_core.sv
// Depth-scaled motion blur core. Pixel words go in on a push/full queue port and
// blurred words come out on an empty/pop queue port; blur_shift sits at APB address 0
// and the user must write it only while no pixel is in flight; the block itself does
// not enforce this. The front part runs each pixel through serial dividers: an accept
// step, the 32-bit span quotient, the 24-bit quotients of the three color shares and a
// hand-off, so full stays high from each accepted word until its job is handed off.
// The back part adds a pixel's span into a MAX_SPAN-entry shifting window and emits
// words as positions finish; at a row end it emits up to MAX_SPAN/2+1 words, one per
// cycle while pop keeps the output word free. A two-entry job queue sits between them;
// with pop held low the queue fills and then the front holds full high.
// Top level; depends on dsmb_pkg, dsmb_front, dsmb_queue, dsmb_back.
module depth_scaled_motion_blur_core #(
    parameter int MaxSpan     = dsmb_pkg::DefMaxSpan,
    parameter int MaxRowWidth = dsmb_pkg::DefMaxRowWidth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [dsmb_pkg::ChanW-1:0]   i_red,
    input  logic [dsmb_pkg::ChanW-1:0]   i_green,
    input  logic [dsmb_pkg::ChanW-1:0]   i_blue,
    input  logic [dsmb_pkg::DepthW-1:0]  i_depth,
    input  logic                         i_depth_finite,
    input  logic                         i_row_end,
    output logic                         empty,
    input  logic                         pop,
    output logic [dsmb_pkg::OutW-1:0]    o_out_red,
    output logic [dsmb_pkg::OutW-1:0]    o_out_green,
    output logic [dsmb_pkg::OutW-1:0]    o_out_blue,
    output logic                         o_out_row_end
);
    import dsmb_pkg::*;
    logic [ShiftW-1:0] r_blur_shift;
    logic fj_valid, fj_ready, bj_valid, bj_take;
    t_job fj, bj;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_blur_shift <= '0;
        else if (psel && penable && pwrite && paddr == RegBlurShift[1:0])
            r_blur_shift <= pwdata[ShiftW-1:0];
    end
    assign prdata = (paddr == RegBlurShift[1:0]) ? 32'(r_blur_shift) : '0;

    dsmb_front #(.MaxSpan(MaxSpan)) u_front (
        .i_clk, .i_rst_n, .i_blur_shift(r_blur_shift), .i_push(push), .o_full(full),
        .i_red, .i_green, .i_blue, .i_depth, .i_depth_finite, .i_row_end,
        .o_job_valid(fj_valid), .i_job_ready(fj_ready), .o_job(fj)
    );
    dsmb_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(fj_valid), .o_wr_ready(fj_ready), .i_data(fj),
        .o_rd_valid(bj_valid), .i_rd(bj_take), .o_data(bj)
    );
    dsmb_back #(.MaxSpan(MaxSpan), .MaxRowWidth(MaxRowWidth)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(bj_valid), .o_job_take(bj_take), .i_job(bj),
        .o_empty(empty), .i_pop(pop), .o_out_red, .o_out_green, .o_out_blue,
        .o_out_row_end
    );
endmodule

>>> tb/tb.sv
// Testbench for depth_scaled_motion_blur_core: directed and random pixel rows with
// random idling, checked word by word against a built-in blur predictor.
// Depends on dsmb_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsmb_pkg::*;

    localparam int Span    = DefMaxSpan;
    localparam int Slots   = Span + 2;
    localparam int RowMax  = DefMaxRowWidth;
    localparam int Settle  = 200;

    typedef struct {
        logic [OutW-1:0] red;
        logic [OutW-1:0] green;
        logic [OutW-1:0] blue;
        logic            row_end;
    } t_blur_word;

    class t_blur_scoreboard;
        logic [ShiftW-1:0] shift;
        int unsigned acc_r [Slots];
        int unsigned acc_g [Slots];
        int unsigned acc_b [Slots];
        int unsigned col;
        t_blur_word pending_words[$];
        int errors;

        function new();
            shift = 0;
            col = 0;
            errors = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (acc_r[i]) begin
                acc_r[i] = 0;
                acc_g[i] = 0;
                acc_b[i] = 0;
            end
        endfunction

        function int unsigned sat(int unsigned a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > AccMax) ? AccMax : s;
        endfunction

        function logic [OutW-1:0] clamp(int unsigned v);
            return (v > OneQ12) ? OneQ12 : v[OutW-1:0];
        endfunction

        function void leave(longint p, bit last);
            t_blur_word w;
            int slot;
            slot = int'(p % Slots);
            w.red = clamp(acc_r[slot]);
            w.green = clamp(acc_g[slot]);
            w.blue = clamp(acc_b[slot]);
            w.row_end = last;
            acc_r[slot] = 0;
            acc_g[slot] = 0;
            acc_b[slot] = 0;
            pending_words = {pending_words, w};
        endfunction

        function void note_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                 logic [ChanW-1:0] b, logic [DepthW-1:0] dep,
                                 logic finite, logic re);
            longint dv, dq, x, p;
            int unsigned sr, sg, sb;
            int slot;
            dv = finite ? longint'(dep) : longint'(NonFiniteDepth);
            dq = (longint'(shift) * 655360) / (10 * dv + 256);
            if (dq < 256) dq = 256;
            if (dq > Span * 256) dq = Span * 256;
            sr = 32'((longint'(r) << 8) / dq);
            sg = 32'((longint'(g) << 8) / dq);
            sb = 32'((longint'(b) << 8) / dq);
            x = col;
            for (longint s = -(dq >> 9); s * 512 < dq; s++) begin
                p = x + s;
                if (p >= 0) begin
                    slot = int'(p % Slots);
                    acc_r[slot] = sat(acc_r[slot], sr);
                    acc_g[slot] = sat(acc_g[slot], sg);
                    acc_b[slot] = sat(acc_b[slot], sb);
                end
            end
            if (re || col >= RowMax - 1) begin
                p = x - Span / 2;
                if (p < 0) p = 0;
                for (; p <= x; p++) leave(p, p == x);
                clear_window();
                col = 0;
            end else begin
                if (x >= Span / 2) leave(x - Span / 2, 1'b0);
                col++;
            end
        endfunction

        function void check_word(logic [OutW-1:0] r, logic [OutW-1:0] g,
                                 logic [OutW-1:0] b, logic re);
            t_blur_word w;
            if (pending_words.size() == 0) begin
                $error("unexpected word: red %0d green %0d blue %0d row_end %0b",
                       r, g, b, re);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (r !== w.red) begin
                $error("out_red: expected %0d, got %0d", w.red, r);
                errors++;
            end
            if (g !== w.green) begin
                $error("out_green: expected %0d, got %0d", w.green, g);
                errors++;
            end
            if (b !== w.blue) begin
                $error("out_blue: expected %0d, got %0d", w.blue, b);
                errors++;
            end
            if (re !== w.row_end) begin
                $error("out_row_end: expected %0b, got %0b", w.row_end, re);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic [ChanW-1:0] i_red = '0, i_green = '0, i_blue = '0;
    logic [DepthW-1:0] i_depth = '0;
    logic i_depth_finite = 1'b0, i_row_end = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [OutW-1:0] o_out_red, o_out_green, o_out_blue;
    logic o_out_row_end;

    t_blur_scoreboard sb = new();
    bit calm_sender = 0;   // no idling on the input side
    bit calm_sink = 0;

    depth_scaled_motion_blur_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_shift(logic [ShiftW-1:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = RegBlurShift[1:0];
        pwdata = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.shift = v;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                              logic [ChanW-1:0] b, logic [DepthW-1:0] dep,
                              logic finite, logic re);
        int n;
        n = calm_sender ? 0 : gap_len();
        repeat (n) @(negedge i_clk);
        @(negedge i_clk);
        push = 1'b1;
        i_red = r;
        i_green = g;
        i_blue = b;
        i_depth = dep;
        i_depth_finite = finite;
        i_row_end = re;
        do @(posedge i_clk); while (full);
        sb.note_pixel(r, g, b, dep, finite, re);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic random_pixel(logic re);
        logic [DepthW-1:0] dep;
        dep = ($urandom_range(0, 3) == 0) ? DepthW'($urandom) :
              DepthW'($urandom_range(0, 64 * 256));
        send_pixel(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom), dep,
                   $urandom_range(0, 9) != 0, re);
    endtask

    task automatic random_rows(int count);
        int len;
        while (count > 0) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 80) :
                  $urandom_range(1, 40);
            for (int i = 0; i < len; i++) random_pixel(i == len - 1);
            count -= len;
            calm_sender = ($urandom_range(0, 5) == 0);
        end
        calm_sender = 0;
    endtask

    // result side: pop decided at falling edge, word taken at rising edge
    initial begin
        int n;
        forever begin
            n = calm_sink ? 0 : gap_len();
            @(negedge i_clk);
            pop = 1'b0;
            repeat (n) @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_word(o_out_red, o_out_green, o_out_blue, o_out_row_end);
        end
    end

    initial begin
        #20ms;
        $display("depth_scaled_motion_blur_core regression: fail");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: long spans, extreme colors and depths
        write_shift(12'd4095);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 1'b1, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b1, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_pixel(16'h1000, 16'h1000, 16'h1000, 24'hFFFFFF, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd256, 1'b1, 1'b0);
        for (int i = 0; i < 14; i++)
            send_pixel(16'hFFFF, 16'h8000, 16'h0001, 24'(i * 64), 1'b1, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 1'b1, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 16'hFFFF, 24'd0, 1'b1, 1'b1);   // one-pixel row
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd100, 1'b0, 1'b0);
        send_pixel(16'h0800, 16'h0800, 16'h0800, 24'd0, 1'b1, 1'b1);
        drain();

        write_shift(12'd0);
        random_rows(50);
        drain();
        write_shift(12'd1);
        random_rows(40);
        drain();
        write_shift(12'd300);
        random_rows(60);
        drain();
        write_shift(ShiftW'($urandom));
        random_rows(60);
        drain();
        calm_sink = 1;
        write_shift(12'd4095);
        random_rows(80);
        calm_sink = 0;
        drain();

        if (sb.errors == 0)
            $display("depth_scaled_motion_blur_core regression: pass");
        else
            $display("depth_scaled_motion_blur_core regression: fail");
        $finish;
    end
endmodule
